>>> hdl/cst_pkg.sv
// Shared types and codes for the call slot table.
// Used by the slot memory, the sequencer and the top level.
`timescale 1ns / 1ps
package cst_pkg;

   localparam int SLOTS_DEF = 4;

   typedef enum logic [2:0] {
      OP_INCOMING      = 3'd0,
      OP_LOCAL_HANGUP  = 3'd1,
      OP_REMOTE_HANGUP = 3'd2,
      OP_ESTABLISHED   = 3'd3,
      OP_RESUMED       = 3'd4,
      OP_HELD          = 3'd5,
      OP_DIAL          = 3'd6,
      OP_QUERY         = 3'd7
   } opcode_type;

   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_DIALING     = 3'd1;
   localparam logic [2:0] ST_RINGING     = 3'd2;
   localparam logic [2:0] ST_ESTABLISHED = 3'd3;
   localparam logic [2:0] ST_HELD        = 3'd4;

   localparam logic [1:0] OUT_DONE    = 2'd0;
   localparam logic [1:0] OUT_IGNORED = 2'd1;
   localparam logic [1:0] OUT_FULL    = 2'd2;

   typedef struct packed {
      logic [3:0] handle;
      logic [7:0] call_id;
      logic [2:0] status;
      logic [1:0] kind;
      logic       is_local;
   } entry_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [3:0] slot_index;
      entry_type  entry;
   } result_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> hdl/cst_if.sv
// Request and response channel interfaces of the call slot table.
// Depends on nothing; widths follow the fixed field widths.
`timescale 1ns / 1ps
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [3:0] phone_handle;
   logic [7:0] remote_call_id;
   logic [1:0] call_kind;
   logic [3:0] query_slot;

   modport source (output valid, opcode, phone_handle, remote_call_id, call_kind,
                   query_slot, input ready);
   modport sink   (input valid, opcode, phone_handle, remote_call_id, call_kind,
                   query_slot, output ready);
endinterface

interface cst_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   logic [3:0] slot_index;
   logic [2:0] slot_status;
   logic [3:0] slot_handle;
   logic [7:0] slot_call_id;
   logic [1:0] slot_kind;
   logic       slot_local;

   modport source (output valid, outcome, slot_index, slot_status, slot_handle,
                   slot_call_id, slot_kind, slot_local, input ready);
   modport sink   (input valid, outcome, slot_index, slot_status, slot_handle,
                   slot_call_id, slot_kind, slot_local, output ready);
endinterface

>>> hdl/cst_mem.sv
// Slot memory: one synchronous read port, one write port, per-slot valid bits.
// Depends on cst_pkg for the entry layout; a slot never written reads as zero.
`timescale 1ns / 1ps
module cst_mem #(
   parameter int SLOTS = 4,
   parameter int IDX_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cst_pkg::mem_ctl_type ctl,
   input  logic [IDX_W-1:0]     rd_addr,
   output cst_pkg::entry_type   rd_data,
   input  logic [IDX_W-1:0]     wr_addr,
   input  cst_pkg::entry_type   wr_data
);
   import cst_pkg::*;

   entry_type        mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;
   entry_type        rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> hdl/cst_ctrl.sv
// Sequencer: scans the slot memory, decides the operation, writes back and
// loads the result register. Depends on cst_pkg and the channel interfaces.
`timescale 1ns / 1ps
module cst_ctrl #(
   parameter int SLOTS = 4,
   parameter int IDX_W = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   cst_req_if.sink               req_ch,
   cst_rsp_if.source             rsp_ch,
   output cst_pkg::mem_ctl_type  ctl,
   output logic [IDX_W-1:0]      rd_addr,
   input  cst_pkg::entry_type    rd_data,
   output logic [IDX_W-1:0]      wr_addr,
   output cst_pkg::entry_type    wr_data
);
   import cst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_WRITE = 4'b0100,
      S_QUERY = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   logic [3:0]       h_ff, h_in;
   logic [7:0]       id_ff, id_in;
   logic [1:0]       kind_ff, kind_in;
   logic [3:0]       q_ff, q_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   entry_type        match_data_ff, match_data_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic      accept;
   logic      out_free;
   logic      hit;
   logic      free_hit;
   logic      q_oor;
   logic      q_oor_new;
   logic      load;
   entry_type fill;

   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign hit       = (rd_data.handle == h_ff) && (rd_data.call_id == id_ff);
   assign free_hit  = (rd_data.handle == 4'd0) && (rd_data.call_id == 8'd0);
   assign q_oor     = ({1'b0, q_ff} >= 5'(SLOTS));
   assign q_oor_new = ({1'b0, req_ch.query_slot} >= 5'(SLOTS));

   always_comb begin
      fill.handle   = h_ff;
      fill.call_id  = id_ff;
      fill.kind     = kind_ff;
      fill.status   = ST_IDLE;
      fill.is_local = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      h_in          = h_ff;
      id_in         = id_ff;
      kind_in       = kind_ff;
      q_in          = q_ff;
      scan_in       = scan_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_data_in = match_data_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_in        = rsp_ff;
      load          = 1'b0;
      ctl.rd_en     = 1'b0;
      ctl.wr_en     = 1'b0;
      rd_addr       = '0;
      wr_addr       = '0;
      wr_data       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = opcode_type'(req_ch.opcode);
               h_in     = req_ch.phone_handle;
               id_in    = req_ch.remote_call_id;
               kind_in  = req_ch.call_kind;
               q_in     = req_ch.query_slot;
               scan_in  = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               if (opcode_type'(req_ch.opcode) == OP_QUERY) begin
                  ctl.rd_en = !q_oor_new;
                  rd_addr   = IDX_W'(req_ch.query_slot);
                  state_in  = S_QUERY;
               end else begin
                  ctl.rd_en = 1'b1;
                  rd_addr   = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!match_ff && hit) begin
               match_in      = 1'b1;
               match_idx_in  = scan_ff;
               match_data_in = rd_data;
            end
            if (!free_ff && free_hit) begin
               free_in     = 1'b1;
               free_idx_in = scan_ff;
            end
            if (scan_ff == LAST) begin
               state_in = S_WRITE;
            end else begin
               scan_in   = scan_ff + 1'b1;
               ctl.rd_en = 1'b1;
               rd_addr   = scan_ff + 1'b1;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               rsp_in   = '0;
               case (op_ff)
                  OP_DIAL, OP_INCOMING: begin
                     if (op_ff == OP_INCOMING && match_ff) begin
                        rsp_in.outcome = OUT_IGNORED;
                     end else if (!free_ff) begin
                        rsp_in.outcome = OUT_FULL;
                     end else begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = free_idx_ff;
                        wr_data   = fill;
                        if (op_ff == OP_DIAL) begin
                           wr_data.status   = ST_DIALING;
                           wr_data.is_local = 1'b1;
                        end else begin
                           wr_data.status = ST_RINGING;
                        end
                     end
                  end
                  OP_LOCAL_HANGUP, OP_REMOTE_HANGUP: begin
                     if (!match_ff) begin
                        rsp_in.outcome = OUT_IGNORED;
                     end else begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = match_idx_ff;
                        wr_data   = '0;
                     end
                  end
                  OP_ESTABLISHED: begin
                     if (match_ff) begin
                        ctl.wr_en      = 1'b1;
                        wr_addr        = match_idx_ff;
                        wr_data        = match_data_ff;
                        wr_data.status = ST_ESTABLISHED;
                     end else if (free_ff) begin
                        ctl.wr_en      = 1'b1;
                        wr_addr        = free_idx_ff;
                        wr_data        = fill;
                        wr_data.status = ST_ESTABLISHED;
                     end else begin
                        rsp_in.outcome = OUT_FULL;
                     end
                  end
                  OP_RESUMED, OP_HELD: begin
                     if (!match_ff) begin
                        rsp_in.outcome = OUT_IGNORED;
                     end else begin
                        ctl.wr_en      = 1'b1;
                        wr_addr        = match_idx_ff;
                        wr_data        = match_data_ff;
                        wr_data.status = (op_ff == OP_HELD) ? ST_HELD : ST_ESTABLISHED;
                     end
                  end
                  default: begin
                     rsp_in.outcome = OUT_IGNORED;
                  end
               endcase
               if (ctl.wr_en) begin
                  rsp_in.outcome    = OUT_DONE;
                  rsp_in.slot_index = 4'(wr_addr);
                  rsp_in.entry      = wr_data;
               end
            end
         end
         S_QUERY: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               rsp_in   = '0;
               rsp_in.slot_index = q_ff;
               if (q_oor) begin
                  rsp_in.outcome = OUT_IGNORED;
               end else begin
                  rsp_in.entry   = rd_data;
                  rsp_in.outcome = (rd_data.status == ST_IDLE) ? OUT_IGNORED : OUT_DONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      h_ff          <= h_in;
      id_ff         <= id_in;
      kind_ff       <= kind_in;
      q_ff          <= q_in;
      scan_ff       <= scan_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_data_ff <= match_data_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.outcome      = rsp_ff.outcome;
   assign rsp_ch.slot_index   = rsp_ff.slot_index;
   assign rsp_ch.slot_status  = rsp_ff.entry.status;
   assign rsp_ch.slot_handle  = rsp_ff.entry.handle;
   assign rsp_ch.slot_call_id = rsp_ff.entry.call_id;
   assign rsp_ch.slot_kind    = rsp_ff.entry.kind;
   assign rsp_ch.slot_local   = rsp_ff.entry.is_local;

endmodule

>>> hdl/call_slot_table.sv
// Top level of the call slot table: sequencer plus slot memory.
// Depends on cst_pkg, cst_if, cst_mem and cst_ctrl.
//
//   channel  | direction | handshake     | payload
//   req_ch   | in        | valid / ready | opcode, handle, call id, kind, query slot
//   rsp_ch   | out       | valid / ready | outcome, slot index, slot contents
//
// An event or dial walks the slots with one memory read per cycle, then decides
// and writes back. A query reads only the slot that it names.
// Reset clears the per-slot valid bits; no clearing pass.
// The result register holds while rsp_ch stalls; the next request word is taken
// while a result waits, and its write-back waits for the register to empty.
`timescale 1ns / 1ps
module call_slot_table #(
   parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
   input logic       clock,
   input logic       reset,
   cst_req_if.sink   req_ch,
   cst_rsp_if.source rsp_ch
);
   import cst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   mem_ctl_type      ctl;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   entry_type        rd_data;
   entry_type        wr_data;

   cst_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   cst_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en))
      else $error("slot memory read and write in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> ({1'b0, wr_addr} < (IDX_W + 1)'(SLOTS)))
      else $error("slot write beyond the table");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a word is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.outcome == OUT_FULL))
         |-> (rsp_ch.slot_index == 4'd0 && rsp_ch.slot_handle == 4'd0
              && rsp_ch.slot_call_id == 8'd0 && rsp_ch.slot_status == ST_IDLE))
      else $error("table full result carries slot contents");
`endif

endmodule
